// File: sv/searchable_fifo_queue_macros.svh
// Assertion macros used by the searchable FIFO queue datapath (sfq_dp).
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SEARCHABLE_FIFO_QUEUE_MACROS_SVH
`define SEARCHABLE_FIFO_QUEUE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SFQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold at the next clock edge after its antecedent.
`define SFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sfq_pkg.sv
// Package for the searchable FIFO queue: sizes, beat types, action codes,
// controller states and the command/status bundles. Depends on nothing.
package sfq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]                   action;
        logic signed [DATA_WIDTH-1:0] value;
    } t_req;

    typedef struct packed {
        logic                         accepted;
        logic signed [DATA_WIDTH-1:0] popped_value;
        logic [CNT_W-1:0]             entry_count;
        logic signed [DATA_WIDTH-1:0] front_value;
        logic signed [DATA_WIDTH-1:0] back_value;
        logic                         is_empty;
        logic                         is_full;
        logic                         hit;
        logic [PTR_W-1:0]             hit_position;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_POP_WB,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic load;
        logic push;
        logic pop;
        logic front_load;
        logic srch_rd;
        logic hit;
        logic step;
        logic reply;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic pos_end;
        logic match;
    } t_status;

    // Circular pointer arithmetic: the sum of a pointer and an offset below
    // DEPTH folded back into the slot range.
    function automatic logic [PTR_W-1:0] sfq_wrap(input logic [PTR_W:0] sum);
        logic [PTR_W:0] folded;
        folded = (sum >= (PTR_W + 1)'(DEPTH)) ? sum - (PTR_W + 1)'(DEPTH) : sum;
        return folded[PTR_W-1:0];
    endfunction

endpackage

// File: sv/searchable_fifo_queue.sv
// Top level of the searchable FIFO queue: joins the controller and the
// datapath. Depends on sfq_pkg, sfq_ctrl and sfq_dp.
//
//   Channel   Handshake           Payload
//   request   start / busy        i_req (t_req: action, value)
//   result    o_valid strobe      o_rsp (t_rsp: accepted .. hit_position)
//   config    i_cfg_we            i_cfg_wdata (capacity)
//
// A request beat is taken at a clock edge where start is high and busy is
// low. Its result shows on o_rsp for exactly one cycle with o_valid high,
// and the receiver cannot stall it. An unused code goes from idle straight
// to the reply state, a push passes the push state, and a pop passes the
// pop state and, if it removes an entry, a write-back state that loads the
// new front from the slot RAM. A search alternates a read state and a
// compare state per entry until it hits or has passed all held entries, as
// it walks the slot RAM's single read port one entry at a time with a
// registered read. Busy drops in the strobe cycle, so the next beat can be
// taken at the edge that takes the result. Reset is synchronous and active
// low; it empties the queue and sets the capacity to the full depth.
module searchable_fifo_queue
    import sfq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_req             i_req,
    output logic             busy,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output logic             o_valid,
    output t_rsp             o_rsp
);

    t_cmd    cmd;
    t_status status;

    // The controller steps each request through its states and issues one
    // command per cycle; of the payload it sees only the action code.
    sfq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_req.action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // The datapath holds the circular slot store, the head pointer and the
    // count, register copies of the front and back entries, and the result
    // register that drives the output beat.
    sfq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

endmodule

// File: sv/sfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sfq_ctrl.sv
// Controller of the searchable FIFO queue: sequences each request.
// Depends on sfq_pkg.
module sfq_ctrl
    import sfq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_action,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_PUSH:   n_state = S_PUSH;
                        ACT_POP:    n_state = S_POP;
                        ACT_SEARCH: n_state = S_SRCH_RD;
                        default:    n_state = S_REPLY;
                    endcase
                end
            end
            S_PUSH:     n_state = S_REPLY;
            S_POP:      n_state = i_status.empty ? S_REPLY : S_POP_WB;
            S_POP_WB:   n_state = S_REPLY;
            S_SRCH_RD:  n_state = i_status.pos_end ? S_REPLY : S_SRCH_CMP;
            S_SRCH_CMP: n_state = i_status.match ? S_REPLY : S_SRCH_RD;
            S_REPLY:    n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:     o_cmd.load       = i_start;
            S_PUSH:     o_cmd.push       = 1'b1;
            S_POP:      o_cmd.pop        = 1'b1;
            S_POP_WB:   o_cmd.front_load = 1'b1;
            S_SRCH_RD:  o_cmd.srch_rd    = !i_status.pos_end;
            S_SRCH_CMP: begin
                o_cmd.hit  = i_status.match;
                o_cmd.step = !i_status.match;
            end
            S_REPLY:    o_cmd.reply      = 1'b1;
            default:    o_cmd            = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: sv/sfq_dp.sv
// Datapath of the searchable FIFO queue: slot RAM, pointers, front/back
// copies, capacity register and the result register. Depends on sfq_pkg,
// sfq_ram and the assertion macro header.
`include "searchable_fifo_queue_macros.svh"

module sfq_dp
    import sfq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output t_status          o_status,
    output logic             o_valid,
    output t_rsp             o_rsp
);

    logic [CAP_W-1:0]      r_cap;
    logic [PTR_W-1:0]      r_head;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] r_front;
    logic [DATA_WIDTH-1:0] r_back;
    logic [DATA_WIDTH-1:0] r_popped;
    logic                  r_accepted;
    logic                  r_hit;
    logic [PTR_W-1:0]      r_hit_pos;
    logic                  r_valid;
    t_rsp                  r_rsp;

    logic [CNT_W-1:0]      cap_eff;
    logic                  full;
    logic                  empty;
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_waddr;
    logic                  ram_re;
    logic [PTR_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // A capacity of zero acts as one; anything above the depth acts as the depth.
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = CNT_W'(1);
        end else if (int'(r_cap) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(r_cap);
        end
    end

    assign full  = (r_count >= cap_eff);
    assign empty = (r_count == '0);

    assign ram_we    = i_cmd.push && !full;
    assign ram_waddr = sfq_wrap({1'b0, r_head} + (PTR_W + 1)'(r_count));
    assign ram_re    = i_cmd.pop || i_cmd.srch_rd;
    assign ram_raddr = i_cmd.pop ? sfq_wrap({1'b0, r_head} + (PTR_W + 1)'(1))
                                 : sfq_wrap({1'b0, r_head} + (PTR_W + 1)'(r_pos));

    sfq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_W'(DEPTH);
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop && !empty) begin
                r_count <= r_count - CNT_W'(1);
                r_head  <= sfq_wrap({1'b0, r_head} + (PTR_W + 1)'(1));
            end
            r_valid <= i_cmd.reply;
        end
    end

    // Per-request payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value    <= i_req.value;
            r_accepted <= (i_req.action == ACT_SEARCH);
            r_popped   <= '0;
            r_hit      <= 1'b0;
            r_hit_pos  <= '0;
            r_pos      <= '0;
        end
        if (ram_we) begin
            r_back     <= r_value;
            r_accepted <= 1'b1;
            if (empty) begin
                r_front <= r_value;
            end
        end
        if (i_cmd.pop && !empty) begin
            r_popped   <= r_front;
            r_accepted <= 1'b1;
        end
        if (i_cmd.front_load) begin
            r_front <= ram_rdata;
        end
        if (i_cmd.hit) begin
            r_hit     <= 1'b1;
            r_hit_pos <= r_pos[PTR_W-1:0];
        end
        if (i_cmd.step) begin
            r_pos <= r_pos + CNT_W'(1);
        end
        if (i_cmd.reply) begin
            r_rsp.accepted     <= r_accepted;
            r_rsp.popped_value <= r_popped;
            r_rsp.entry_count  <= r_count;
            r_rsp.front_value  <= empty ? '1 : r_front;
            r_rsp.back_value   <= empty ? '1 : r_back;
            r_rsp.is_empty     <= empty;
            r_rsp.is_full      <= full;
            r_rsp.hit          <= r_hit;
            r_rsp.hit_position <= r_hit_pos;
        end
    end

    assign o_status.empty   = empty;
    assign o_status.pos_end = (r_pos == r_count);
    assign o_status.match   = (ram_rdata == r_value);
    assign o_valid          = r_valid;
    assign o_rsp            = r_rsp;

    `SFQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH),
        "held count exceeds the depth")
    `SFQ_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, ram_we,
        r_count == $past(r_count) + CNT_W'(1), "accepted push did not add an entry")
    `SFQ_ASSERT_NEXT(a_pop_head, i_clk, i_rst_n, i_cmd.pop && !empty,
        r_count == $past(r_count) - CNT_W'(1), "accepted pop did not remove an entry")

endmodule
